[rtl/core/frb_pkg.sv]
// Package for the fragment reassembly buffer: item types, command and
// status codes, controller states and the message key hash.
// No dependencies.
package frb_pkg;

   // Defaults for the top-level parameters
   localparam int ENTRIES_DEF    = 8;
   localparam int MSG_BYTES_DEF  = 1024;
   localparam int MAX_PIECES_DEF = 64;

   // Received bitmap is stored as rows of MAP_W flags
   localparam int MAP_W  = 32;
   localparam int MAP_LW = 5;
   localparam int HASH_W = 17;
   localparam int POS_W  = 13;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_READ    = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_QUERY   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_COMPLETE = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_OK       = 3'd4,
      ST_MISSING  = 3'd5,
      ST_NONE     = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  source_node;
      logic [7:0]  dest_node;
      logic [15:0] sequence_number;
      logic [4:0]  arrival_link;
      logic [9:0]  byte_offset;
      logic [7:0]  payload_byte;
      logic        fragment_end;
      logic [10:0] message_length;
      logic [10:0] piece_size;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] read_byte;
      logic [9:0] missing_position;
      logic       last_result;
   } rsp_item_type;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_CLR  = 11'b000_0000_0010,
      S_LOOK = 11'b000_0000_0100,
      S_WRD  = 11'b000_0000_1000,
      S_WMOD = 11'b000_0001_0000,
      S_WFIN = 11'b000_0010_0000,
      S_RRD  = 11'b000_0100_0000,
      S_RFIN = 11'b000_1000_0000,
      S_QRD  = 11'b001_0000_0000,
      S_QCHK = 11'b010_0000_0000,
      S_QEND = 11'b100_0000_0000
   } state_type;

   // Message key hash: src*13 + dest*7 + seqno
   function automatic logic [HASH_W-1:0] hash_of(input logic [7:0] src,
                                                 input logic [7:0] dst,
                                                 input logic [15:0] seq);
      hash_of = HASH_W'(src) * HASH_W'(13) + HASH_W'(dst) * HASH_W'(7) + HASH_W'(seq);
   endfunction

endpackage

[rtl/core/frb_req_if.sv]
// Request channel of the fragment reassembly buffer.
// Depends on frb_pkg.
interface frb_req_if import frb_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/frb_rsp_if.sv]
// Response channel of the fragment reassembly buffer.
// Depends on frb_pkg.
interface frb_rsp_if import frb_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/fragment_reassembly_buffer.sv]
// Fragment reassembly buffer: a write steps through table lookup, bitmap
// read, read-modify-write, report and return to idle; a read through lookup,
// bitmap and store read, and report; a release answers from the lookup; a
// query reads and checks each scanned piece position, reporting missing ones;
// one item at a time. Allocation of a slot first clears its bitmap rows.
// After reset the whole bitmap is cleared, with no item accepted.
// Depends on frb_pkg, frb_req_if, frb_rsp_if.
module fragment_reassembly_buffer import frb_pkg::*; #(
   parameter int ENTRIES    = ENTRIES_DEF,
   parameter int MSG_BYTES  = MSG_BYTES_DEF,
   parameter int MAX_PIECES = MAX_PIECES_DEF
) (
   input logic      clock,
   input logic      reset,
   frb_req_if.sink   req_chan,
   frb_rsp_if.source rsp_chan
);

   localparam int SW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OW   = $clog2(MSG_BYTES);
   localparam int RW   = OW - MAP_LW;
   localparam int AW   = SW + OW;
   localparam int MAW  = SW + RW;
   localparam int NW   = $clog2(MAX_PIECES + 1);
   localparam int CW   = OW + 1;
   localparam int ROWS = ENTRIES * (MSG_BYTES / MAP_W);

   // Storage
   logic [7:0]       store_mem [ENTRIES*MSG_BYTES];
   logic [MAP_W-1:0] map_mem [ROWS];
   logic [7:0]       store_rd_ff;
   logic [MAP_W-1:0] map_rd_ff;

   // Slot table
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [HASH_W-1:0]  hash_tab_ff [ENTRIES];
   logic [4:0]         link_tab_ff [ENTRIES];
   logic [CW-1:0]      count_ff [ENTRIES];

   // Controller
   state_type        state_ff, state_in;
   req_item_type     item_ff;
   logic [HASH_W-1:0] hash_ff;
   logic [SW-1:0]    slot_ff, slot_in;
   logic [MAW-1:0]   clr_ff, clr_in, clr_end_ff, clr_end_in;
   logic             clr_alloc_ff, clr_alloc_in;
   logic [11:0]      pos_ff, pos_in;
   logic [NW-1:0]    n_ff, n_in;
   logic             pend_ff, pend_in;
   logic [9:0]       pend_pos_ff, pend_pos_in;
   logic             out_valid_ff, out_valid_in;
   rsp_item_type     out_ff, out_in;

   // Table update requests
   logic alloc_req, count_inc, release_req;

   // Memory access
   logic [MAW-1:0]   map_raddr, map_waddr;
   logic             map_we;
   logic [MAP_W-1:0] map_wdata;
   logic             store_we;
   logic [AW-1:0]    store_addr;

   // Lookup
   logic [ENTRIES-1:0] hit_vec, rel_vec;
   logic               hit_any, full;
   logic [SW-1:0]      hit_idx, free_idx;

   always_comb begin
      hit_any  = 1'b0;
      full     = 1'b1;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rel_vec[i] = valid_ff[i] && (hash_tab_ff[i] == hash_ff);
         hit_vec[i] = rel_vec[i] && (link_tab_ff[i] == item_ff.arrival_link);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_any = 1'b1;
            hit_idx = SW'(i);
         end
         if (!valid_ff[i]) begin
            full     = 1'b0;
            free_idx = SW'(i);
         end
      end
   end

   // Address and limit arithmetic
   logic [POS_W-1:0] off_w, pos_w, lim, next_pos, mlen_w;
   logic [OW-1:0]    off_idx, pos_idx;
   logic             off_ok;
   logic [10:0]      step_eff;
   logic             can_emit;

   assign off_w    = POS_W'(item_ff.byte_offset);
   assign pos_w    = POS_W'(pos_ff);
   assign mlen_w   = POS_W'(item_ff.message_length);
   assign off_ok   = off_w < POS_W'(MSG_BYTES);
   assign off_idx  = off_w[OW-1:0];
   assign pos_idx  = pos_w[OW-1:0];
   assign lim      = (mlen_w < POS_W'(MSG_BYTES)) ? mlen_w : POS_W'(MSG_BYTES);
   assign step_eff = (item_ff.piece_size == 11'd0) ? 11'd1 : item_ff.piece_size;
   assign next_pos = pos_w + POS_W'(step_eff);
   assign can_emit = !out_valid_ff || rsp_chan.ready;

   assign store_addr = {slot_ff, off_idx};
   assign map_raddr  = (state_ff == S_QRD || state_ff == S_QCHK) ?
                       {slot_ff, pos_idx[OW-1:MAP_LW]} : {slot_ff, off_idx[OW-1:MAP_LW]};

   // Controller next state
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      clr_end_in   = clr_end_ff;
      clr_alloc_in = clr_alloc_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      pend_in      = pend_ff;
      pend_pos_in  = pend_pos_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      alloc_req    = 1'b0;
      count_inc    = 1'b0;
      release_req  = 1'b0;
      map_we       = 1'b0;
      map_waddr    = clr_ff;
      map_wdata    = '0;
      store_we     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) state_in = S_LOOK;
         end
         S_CLR: begin
            map_we = 1'b1;
            if (clr_ff == clr_end_ff) begin
               state_in = clr_alloc_ff ? S_WRD : S_IDLE;
            end else begin
               clr_in = clr_ff + MAW'(1);
            end
         end
         S_LOOK: begin
            if (can_emit) begin
               out_in = '{status: ST_NOTFOUND, read_byte: 8'd0,
                          missing_position: 10'd0, last_result: 1'b1};
               state_in = S_IDLE;
               case (item_ff.command)
                  CMD_WRITE: begin
                     if (hit_any) begin
                        slot_in  = hit_idx;
                        state_in = S_WRD;
                     end else if (!full) begin
                        alloc_req    = 1'b1;
                        slot_in      = free_idx;
                        clr_in       = {free_idx, {RW{1'b0}}};
                        clr_end_in   = {free_idx, {RW{1'b1}}};
                        clr_alloc_in = 1'b1;
                        state_in     = S_CLR;
                     end else if (item_ff.fragment_end) begin
                        out_in.status = ST_FULL;
                        out_valid_in  = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     slot_in = hit_idx;
                     if (hit_any && off_ok) begin
                        state_in = S_RRD;
                     end else begin
                        if (hit_any) out_in.status = ST_OK;
                        out_valid_in = 1'b1;
                     end
                  end
                  CMD_RELEASE: begin
                     release_req = 1'b1;
                     if (|rel_vec) out_in.status = ST_OK;
                     out_valid_in = 1'b1;
                  end
                  default: begin
                     slot_in = hit_idx;
                     pos_in  = '0;
                     n_in    = '0;
                     pend_in = 1'b0;
                     if (!hit_any) out_valid_in = 1'b1;
                     else if (lim == '0) state_in = S_QEND;
                     else state_in = S_QRD;
                  end
               endcase
            end
         end
         S_WRD: begin
            state_in = off_ok ? S_WMOD : S_WFIN;
         end
         S_WMOD: begin
            store_we  = 1'b1;
            map_we    = 1'b1;
            map_waddr = map_raddr;
            map_wdata = map_rd_ff | (MAP_W'(1) << off_idx[MAP_LW-1:0]);
            count_inc = !map_rd_ff[off_idx[MAP_LW-1:0]];
            state_in  = S_WFIN;
         end
         S_WFIN: begin
            if (!item_ff.fragment_end) begin
               state_in = S_IDLE;
            end else if (can_emit) begin
               out_in = '{status: (POS_W'(count_ff[slot_ff]) == mlen_w) ? ST_COMPLETE
                                                                       : ST_STORED,
                          read_byte: 8'd0, missing_position: 10'd0, last_result: 1'b1};
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RRD: state_in = S_RFIN;
         S_RFIN: begin
            if (can_emit) begin
               out_in = '{status: ST_OK,
                          read_byte: map_rd_ff[off_idx[MAP_LW-1:0]] ? store_rd_ff : 8'd0,
                          missing_position: 10'd0, last_result: 1'b1};
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_QRD: state_in = S_QCHK;
         S_QCHK: begin
            if (!map_rd_ff[pos_idx[MAP_LW-1:0]]) begin
               // Hold a found position until the next one shows it is not last
               if (!pend_ff || can_emit) begin
                  if (pend_ff) begin
                     out_in = '{status: ST_MISSING, read_byte: 8'd0,
                                missing_position: pend_pos_ff, last_result: 1'b0};
                     out_valid_in = 1'b1;
                  end
                  pend_in     = 1'b1;
                  pend_pos_in = pos_ff[9:0];
                  n_in        = n_ff + NW'(1);
                  pos_in      = next_pos[11:0];
                  if (n_ff + NW'(1) == NW'(MAX_PIECES) || next_pos >= lim)
                     state_in = S_QEND;
                  else
                     state_in = S_QRD;
               end
            end else begin
               pos_in   = next_pos[11:0];
               state_in = (next_pos >= lim) ? S_QEND : S_QRD;
            end
         end
         S_QEND: begin
            if (can_emit) begin
               out_in = '{status: pend_ff ? ST_MISSING : ST_NONE, read_byte: 8'd0,
                          missing_position: pend_ff ? pend_pos_ff : 10'd0,
                          last_result: 1'b1};
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Slot valid next value
   always_comb begin
      valid_in = valid_ff;
      if (release_req) valid_in = valid_ff & ~rel_vec;
      if (alloc_req) valid_in[free_idx] = 1'b1;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_end_ff   <= MAW'(ROWS - 1);
         clr_alloc_ff <= 1'b0;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_end_ff   <= clr_end_in;
         clr_alloc_ff <= clr_alloc_in;
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         n_ff         <= n_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      pos_ff      <= pos_in;
      pend_pos_ff <= pend_pos_in;
      out_ff      <= out_in;
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= req_chan.data;
         hash_ff <= hash_of(req_chan.data.source_node, req_chan.data.dest_node,
                            req_chan.data.sequence_number);
      end
      if (alloc_req) begin
         hash_tab_ff[free_idx] <= hash_ff;
         link_tab_ff[free_idx] <= item_ff.arrival_link;
         count_ff[free_idx]    <= '0;
      end else if (count_inc) begin
         count_ff[slot_ff] <= count_ff[slot_ff] + CW'(1);
      end
   end

   // Message store and received bitmap
   always_ff @(posedge clock) begin
      if (store_we) store_mem[store_addr] <= item_ff.payload_byte;
      store_rd_ff <= store_mem[store_addr];
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[map_raddr];
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

   // A key never sits in two slots
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec)) else $error("duplicate slot key");

   // No item taken during a bitmap clear
   a_clr_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> !req_chan.ready) else $error("accept during clear");

   // Only missing-position results may be non-final
   a_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.status != ST_MISSING |-> out_ff.last_result)
      else $error("non-final result with single-result status");

   // An allocation leaves the slot valid and starts its clear
   a_alloc: assert property (@(posedge clock) disable iff (reset)
      alloc_req |=> valid_ff[slot_ff] && state_ff == S_CLR)
      else $error("allocation not taken");

endmodule

[dv/fragment_reassembly_buffer_test.sv]
// Self-checking test of fragment_reassembly_buffer: directed, back-pressure and
// random message traffic checked against an in-bench model of the slot table.
// Depends on frb_pkg, frb_req_if, frb_rsp_if and the block itself.
module fragment_reassembly_buffer_test import frb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = 8;
   localparam int MSG_LEN    = 1024;
   localparam int PIECE_MAX  = 64;
   localparam int LIMIT      = 4000000;
   localparam int POOL       = 12;

   typedef struct {
      logic [7:0]  src;
      logic [7:0]  dst;
      logic [15:0] seq;
      logic [4:0]  link;
      int          mlen;
      int          psize;
   } msg_key_type;

   logic clock;
   logic reset;

   frb_req_if req_chan ();
   frb_rsp_if rsp_chan ();

   fragment_reassembly_buffer u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the slot table
   bit          slot_used [SLOTS];
   logic [16:0] slot_key  [SLOTS];
   logic [4:0]  slot_lnk  [SLOTS];
   int          slot_cnt  [SLOTS];
   logic [7:0]  byte_mem  [SLOTS*MSG_LEN];
   bit          got_map   [SLOTS*MSG_LEN];
   bit          ever_wr   [SLOTS*MSG_LEN];

   rsp_item_type expected_rsp [$];
   msg_key_type  pool [POOL];

   int  cycles;
   int  items_sent;
   int  rsp_seen;
   int  mismatches;
   int  rsp_hold;
   bit  quiet;

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     expected_rsp.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic [16:0] key_hash(logic [7:0] s, logic [7:0] d, logic [15:0] q);
      int v;
      v = int'(s) * 13 + int'(d) * 7 + int'(q);
      return v[16:0];
   endfunction

   function automatic int lookup_slot(logic [16:0] h, logic [4:0] l);
      for (int i = 0; i < SLOTS; i++)
         if (slot_used[i] && slot_key[i] == h && slot_lnk[i] == l) return i;
      return -1;
   endfunction

   function automatic rsp_item_type mk_rsp(status_type st, logic [7:0] rb,
                                           logic [9:0] mp, logic last);
      rsp_item_type r;
      r.status = st;
      r.read_byte = rb;
      r.missing_position = mp;
      r.last_result = last;
      return r;
   endfunction

   // Expected results of one accepted item; updates the shadow table
   task automatic predict_reassembly(req_item_type it);
      logic [16:0] h;
      int s, a, lim, stp, n;
      bit freed;
      h = key_hash(it.source_node, it.dest_node, it.sequence_number);
      s = lookup_slot(h, it.arrival_link);
      case (cmd_type'(it.command))
         CMD_WRITE: begin
            if (s < 0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (!slot_used[i] && s < 0) s = i;
               if (s < 0) begin
                  if (it.fragment_end)
                     expected_rsp.push_back(mk_rsp(ST_FULL, 8'd0, 10'd0, 1'b1));
                  return;
               end
               slot_used[s] = 1'b1;
               slot_key[s] = h;
               slot_lnk[s] = it.arrival_link;
               slot_cnt[s] = 0;
               for (int j = 0; j < MSG_LEN; j++) got_map[s*MSG_LEN + j] = 1'b0;
            end
            a = s*MSG_LEN + int'(it.byte_offset);
            byte_mem[a] = it.payload_byte;
            ever_wr[a] = 1'b1;
            if (!got_map[a]) begin
               got_map[a] = 1'b1;
               slot_cnt[s]++;
            end
            if (it.fragment_end)
               expected_rsp.push_back(mk_rsp(slot_cnt[s] == int'(it.message_length) ?
                                             ST_COMPLETE : ST_STORED, 8'd0, 10'd0, 1'b1));
         end
         CMD_READ: begin
            if (s < 0) expected_rsp.push_back(mk_rsp(ST_NOTFOUND, 8'd0, 10'd0, 1'b1));
            else begin
               a = s*MSG_LEN + int'(it.byte_offset);
               expected_rsp.push_back(mk_rsp(ST_OK, got_map[a] ? byte_mem[a] : 8'd0,
                                             10'd0, 1'b1));
            end
         end
         CMD_RELEASE: begin
            freed = 1'b0;
            for (int i = 0; i < SLOTS; i++)
               if (slot_used[i] && slot_key[i] == h) begin
                  slot_used[i] = 1'b0;
                  freed = 1'b1;
               end
            expected_rsp.push_back(mk_rsp(freed ? ST_OK : ST_NOTFOUND, 8'd0, 10'd0, 1'b1));
         end
         default: begin
            if (s < 0) begin
               expected_rsp.push_back(mk_rsp(ST_NOTFOUND, 8'd0, 10'd0, 1'b1));
               return;
            end
            stp = (it.piece_size == 0) ? 1 : int'(it.piece_size);
            lim = (int'(it.message_length) > MSG_LEN) ? MSG_LEN : int'(it.message_length);
            n = 0;
            for (int p = 0; p < lim && n < PIECE_MAX; p += stp)
               if (!got_map[s*MSG_LEN + p]) begin
                  expected_rsp.push_back(mk_rsp(ST_MISSING, 8'd0, p[9:0], 1'b0));
                  n++;
               end
            if (n == 0) expected_rsp.push_back(mk_rsp(ST_NONE, 8'd0, 10'd0, 1'b1));
            else expected_rsp[$].last_result = 1'b1;
         end
      endcase
   endtask

   // Send one item, record its results, then maybe leave a gap
   task automatic send_item(req_item_type it);
      int gap, pick;
      req_chan.valid <= 1'b1;
      req_chan.data <= it;
      do @(posedge clock); while (!req_chan.ready);
      predict_reassembly(it);
      items_sent++;
      pick = $urandom_range(99);
      if (quiet || pick < 60) gap = 0;
      else if (pick < 92) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_item_type mk_req(cmd_type c, msg_key_type k, int off,
                                           logic [7:0] d, logic fe);
      req_item_type it;
      it.command = c;
      it.source_node = k.src;
      it.dest_node = k.dst;
      it.sequence_number = k.seq;
      it.arrival_link = k.link;
      it.byte_offset = off[9:0];
      it.payload_byte = d;
      it.fragment_end = fe;
      it.message_length = k.mlen[10:0];
      it.piece_size = k.psize[10:0];
      return it;
   endfunction

   // Reads may only touch store bytes written at some time
   function automatic bool_ok_read(req_item_type it);
      int s;
      s = lookup_slot(key_hash(it.source_node, it.dest_node, it.sequence_number),
                      it.arrival_link);
      return (s < 0) || ever_wr[s*MSG_LEN + int'(it.byte_offset)];
   endfunction

   task automatic wait_drain();
      while (expected_rsp.size() > 0) @(posedge clock);
   endtask

   // Response ready: short and long stalls, or a forced hold-off
   initial begin
      int stall;
      int pick;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold--;
         end else if (stall > 0 && !quiet) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            pick = $urandom_range(99);
            if (pick < 22) stall = $urandom_range(3, 1);
            else if (pick < 25) stall = $urandom_range(60, 20);
         end
      end
   end

   // Result checker
   initial begin
      rsp_item_type want, got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result st=%0d rb=%0h mp=%0d last=%0b", got.status,
                           got.read_byte, got.missing_position, got.last_result);
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status || got.read_byte !== want.read_byte ||
                   got.missing_position !== want.missing_position ||
                   got.last_result !== want.last_result) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: exp st=%0d rb=%0h mp=%0d last=%0b, got st=%0d rb=%0h mp=%0d last=%0b",
                              rsp_seen, want.status, want.read_byte, want.missing_position,
                              want.last_result, got.status, got.read_byte,
                              got.missing_position, got.last_result);
               end
            end
         end
      end
   end

   // Extremes, misses, repeated byte, shared hash, full table, stale byte
   task automatic test_directed();
      msg_key_type ka, kb, kc;
      ka = '{8'hFF, 8'hFF, 16'hFFFF, 5'd31, 2, 1024};
      kb = '{8'h00, 8'h00, 16'h0000, 5'd0, 0, 16};
      kc = '{8'h12, 8'h34, 16'h0056, 5'd0, 5, 16};
      send_item(mk_req(CMD_WRITE, ka, 0, 8'hA5, 1'b0));
      send_item(mk_req(CMD_WRITE, ka, 1023, 8'h5A, 1'b1));
      send_item(mk_req(CMD_READ, ka, 1023, 8'h00, 1'b0));
      send_item(mk_req(CMD_WRITE, ka, 0, 8'hFF, 1'b1));
      send_item(mk_req(CMD_READ, ka, 0, 8'h00, 1'b0));
      send_item(mk_req(CMD_QUERY, ka, 0, 8'h00, 1'b0));
      ka.mlen = 1024; ka.psize = 16;
      send_item(mk_req(CMD_QUERY, ka, 0, 8'h00, 1'b0));
      ka.mlen = 40; ka.psize = 0;
      send_item(mk_req(CMD_QUERY, ka, 0, 8'h00, 1'b0));
      send_item(mk_req(CMD_READ, kb, 3, 8'h00, 1'b0));
      send_item(mk_req(CMD_QUERY, kb, 0, 8'h00, 1'b0));
      send_item(mk_req(CMD_RELEASE, kb, 0, 8'h00, 1'b0));
      // same hash on two links, freed together
      send_item(mk_req(CMD_WRITE, kc, 4, 8'h11, 1'b1));
      kc.link = 5'd1;
      send_item(mk_req(CMD_WRITE, kc, 4, 8'h22, 1'b1));
      send_item(mk_req(CMD_RELEASE, kc, 0, 8'h00, 1'b0));
      kc.link = 5'd0;
      send_item(mk_req(CMD_READ, kc, 4, 8'h00, 1'b0));
      // fill the table, then overflow with and without fragment end
      for (int i = 0; i < 7; i++)
         send_item(mk_req(CMD_WRITE, pool[i], 0, 8'(i), 1'b1));
      send_item(mk_req(CMD_WRITE, pool[7], 2, 8'h77, 1'b0));
      send_item(mk_req(CMD_WRITE, pool[7], 3, 8'h78, 1'b1));
      // slot reused: byte written earlier but not received since
      ka.mlen = 2; ka.psize = 1024;
      send_item(mk_req(CMD_RELEASE, ka, 0, 8'h00, 1'b0));
      send_item(mk_req(CMD_WRITE, ka, 0, 8'h3C, 1'b0));
      send_item(mk_req(CMD_READ, ka, 1023, 8'h00, 1'b0));
      req_chan.valid <= 1'b0;
   endtask

   // Receiver holds off while the sender keeps offering items
   task automatic test_backpressure();
      quiet = 1'b1;
      rsp_hold = 1500;
      for (int i = 0; i < 20; i++)
         send_item(mk_req(CMD_READ, pool[i % POOL], 0, 8'h00, 1'b0));
      quiet = 1'b0;
      req_chan.valid <= 1'b0;
      wait_drain();
   endtask

   // Fragmented messages with random content, plus noise
   task automatic test_random();
      req_item_type it;
      msg_key_type k;
      int pick, start, len;
      while (items_sent < 320) begin
         if ($urandom_range(15) == 0) quiet = ~quiet;
         k = pool[$urandom_range(POOL-1)];
         if ($urandom_range(9) == 0) k.link = 5'($urandom);
         pick = $urandom_range(99);
         if (pick < 55) begin
            start = $urandom_range(k.mlen - 1);
            len = $urandom_range(8, 1);
            for (int b = 0; b < len && start + b < k.mlen; b++)
               send_item(mk_req(CMD_WRITE, k, start + b, 8'($urandom),
                                (b == len - 1) || (start + b == k.mlen - 1)));
         end else if (pick < 70) begin
            it = mk_req(CMD_READ, k, $urandom_range(k.mlen - 1), 8'($urandom), 1'b0);
            if (bool_ok_read(it)) send_item(it);
         end else if (pick < 80) begin
            send_item(mk_req(CMD_QUERY, k, 0, 8'($urandom), 1'b0));
         end else if (pick < 90) begin
            send_item(mk_req(CMD_RELEASE, k, 0, 8'($urandom), 1'b0));
         end else begin
            it = req_item_type'(80'({$urandom, $urandom, $urandom}));
            it.message_length = 11'($urandom_range(1024));
            it.piece_size = 11'($urandom_range(1024, 16));
            if (it.command != CMD_READ || bool_ok_read(it)) send_item(it);
         end
      end
      quiet = 1'b0;
   endtask

   // Main sequence
   initial begin
      items_sent = 0;
      rsp_seen = 0;
      mismatches = 0;
      rsp_hold = 0;
      quiet = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      for (int i = 0; i < SLOTS*MSG_LEN; i++) begin
         got_map[i] = 1'b0;
         ever_wr[i] = 1'b0;
      end
      for (int i = 0; i < POOL; i++) begin
         pool[i].src = 8'($urandom);
         pool[i].dst = 8'($urandom);
         pool[i].seq = 16'($urandom) + 16'(i);
         pool[i].link = 5'($urandom);
         pool[i].mlen = ($urandom_range(7) == 0) ? 1024 : $urandom_range(40, 8);
         pool[i].psize = ($urandom_range(5) == 0) ? 1024 : $urandom_range(24, 16);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drain();
      test_backpressure();
      test_random();
      req_chan.valid <= 1'b0;
      wait_drain();
      repeat (200) @(posedge clock);
      $display("sent %0d items, checked %0d results over write, read, release and query",
               items_sent, rsp_seen);
      $display("including a full table, shared hashes, slot reuse and a long receiver stall");
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_rsp.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
